[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the flash sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFCQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/sfcq_pkg.sv]
// ----------------------------------------------------------------------------
// sfcq_pkg
// Types, codes and helpers of the SPI flash command queue sequencer.
// ----------------------------------------------------------------------------
package sfcq_pkg;

  // Default parameter values
  localparam int unsigned QUEUE_DEPTH_DEF      = 64;
  localparam int unsigned ERASE_BLOCK_SIZE_DEF = 65536;
  localparam int unsigned ADDRESS_BITS_DEF     = 24;

  // Fixed field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned OP_W    = 8;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_VAL_W = 13;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PROGRAM = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DONE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TIMER   = 3'd4;

  // Actions
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_XFER  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMER = 2'd2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_PROGRAM = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE   = 2'd2;

  // Transfer phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ENABLE  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PROGRAM = 3'd2;
  localparam logic [PHASE_W-1:0] PH_READ    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ERASE   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STATUS  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP_WREN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_PROG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OP_READ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OP_ERASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OP_STATUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 3'd5;

  // Register reset values
  localparam logic [OP_W-1:0]  RST_OP_WREN   = 8'd6;
  localparam logic [OP_W-1:0]  RST_OP_PROG   = 8'd2;
  localparam logic [OP_W-1:0]  RST_OP_READ   = 8'd3;
  localparam logic [OP_W-1:0]  RST_OP_ERASE  = 8'd216;
  localparam logic [OP_W-1:0]  RST_OP_STATUS = 8'd5;
  localparam logic [LEN_W-1:0] RST_PAGE_SIZE = 13'd256;

  // Transfer lengths and address handling
  localparam logic [LEN_W-1:0]  LEN_ENABLE   = 13'd1;
  localparam logic [LEN_W-1:0]  LEN_STATUS   = 13'd2;
  localparam logic [LEN_W-1:0]  LEN_ERASE    = 13'd4;
  localparam logic [LEN_W-1:0]  LEN_OVERHEAD = 13'd4;
  localparam logic [LEN_W-1:0]  PAGE_MAX     = 13'd4096;
  localparam logic [ADDR_W-1:0] ERASE_ADDR_MASK = 24'hFF0000;
  localparam int unsigned       STATUS_BUSY_BIT = 0;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] flash_address;
    logic [ADDR_W-1:0] end_address;
    logic [TAG_W-1:0]  buffer_tag;
    logic [7:0]        status_byte;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [OP_W-1:0]   spi_opcode;
    logic [ADDR_W-1:0] spi_address;
    logic [LEN_W-1:0]  transfer_length;
    logic              uses_buffer;
    logic [TAG_W-1:0]  out_buffer_tag;
    logic              busy_res;
    logic              queue_overflow;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_t;

  // Page size clamped to 1..4096, plus opcode and address bytes
  function automatic logic [LEN_W-1:0] page_len(input logic [LEN_W-1:0] psize);
    logic [LEN_W-1:0] p;
    p = psize;
    if (p == '0) p = 13'd1;
    if (p > PAGE_MAX) p = PAGE_MAX;
    return p + LEN_OVERHEAD;
  endfunction

  // Result of a transfer start; status fields are filled at the output stage
  function automatic rsp_t make_xfer(input logic [OP_W-1:0] op,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [LEN_W-1:0] len,
                                     input logic buf_use,
                                     input logic [TAG_W-1:0] tag);
    rsp_t r;
    r = '0;
    r.action          = ACT_XFER;
    r.spi_opcode      = op;
    r.spi_address     = addr;
    r.transfer_length = len;
    r.uses_buffer     = buf_use;
    r.out_buffer_tag  = buf_use ? tag : '0;
    return r;
  endfunction

endpackage

[sv/sfcq_stream_if.sv]
// ----------------------------------------------------------------------------
// sfcq_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface sfcq_stream_if #(
  parameter type T = logic
) (
  input logic clk_i,
  input logic rst_ni
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

[sv/spi_flash_command_queue_sequencer_core.sv]
// ----------------------------------------------------------------------------
// spi_flash_command_queue_sequencer_core
// Request ring plus phase sequencer that drives SPI NOR flash transfers.
// ----------------------------------------------------------------------------
// Flow: a request is taken in S_IDLE and decoded in S_CMD; an enqueue then fills
//   ring slots in S_ENQ, and a start reads the ring through S_RD and S_EXEC.
// Throughput: one item at a time; the next item is taken only after the result
//   is loaded into the output register, which waits while the output stalls.
// Reset: pointers, busy flag, phase and config registers reset; ring and payload registers do not.
module spi_flash_command_queue_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH      = sfcq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ERASE_BLOCK_SIZE = sfcq_pkg::ERASE_BLOCK_SIZE_DEF,
  parameter int unsigned ADDRESS_BITS     = sfcq_pkg::ADDRESS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfcq_stream_if.sink   req_i,
  sfcq_stream_if.source rsp_o,
  sfcq_stream_if.sink   cfg_i
);
  import sfcq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned EAW   = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int unsigned AW1   = ADDR_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_ENQ  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_ENABLE = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [EAW-1:0]    addr;
  } entry_t;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_q;

  logic [2:0]         state_q, state_d;
  logic               mode_q, mode_d;
  req_t               item_q;
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic               busy_q, busy_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               ovf_q, ovf_d;
  rsp_t               res_q, res_d;
  logic [AW1-1:0]     a_q, a_d, end_q, end_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic               out_valid_q;
  rsp_t               out_q;

  logic [OP_W-1:0]    op_wren_q, op_prog_q, op_read_q, op_erase_q, op_status_q;
  logic [LEN_W-1:0]   page_size_q;

  logic [PTR_W-1:0]   head_nx, tail_nx;
  logic               wr_en;
  entry_t             wr_entry;
  logic               out_free;

  assign head_nx = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nx = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  assign wr_entry.kind = kind_q;
  assign wr_entry.tag  = tag_q;
  assign wr_entry.addr = a_q[EAW-1:0];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_wren_q   <= RST_OP_WREN;
      op_prog_q   <= RST_OP_PROG;
      op_read_q   <= RST_OP_READ;
      op_erase_q  <= RST_OP_ERASE;
      op_status_q <= RST_OP_STATUS;
      page_size_q <= RST_PAGE_SIZE;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_OP_WREN:   op_wren_q   <= cfg_i.data.value[OP_W-1:0];
        REG_OP_PROG:   op_prog_q   <= cfg_i.data.value[OP_W-1:0];
        REG_OP_READ:   op_read_q   <= cfg_i.data.value[OP_W-1:0];
        REG_OP_ERASE:  op_erase_q  <= cfg_i.data.value[OP_W-1:0];
        REG_OP_STATUS: op_status_q <= cfg_i.data.value[OP_W-1:0];
        REG_PAGE_SIZE: page_size_q <= cfg_i.data.value[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[head_q] <= wr_entry;
    if (state_q == S_RD) rd_q <= mem_q[tail_q];
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    head_d  = head_q;
    tail_d  = tail_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    ovf_d   = ovf_q;
    res_d   = res_q;
    a_d     = a_q;
    end_d   = end_q;
    kind_d  = kind_q;
    tag_d   = tag_q;
    wr_en   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_CMD;
      end

      S_CMD: begin
        res_d   = '0;
        ovf_d   = 1'b0;
        mode_d  = MODE_START;
        state_d = S_OUT;
        a_d     = {1'b0, item_q.flash_address};
        end_d   = {1'b0, item_q.flash_address};
        kind_d  = item_q.command[KIND_W-1:0];
        tag_d   = item_q.buffer_tag;
        case (item_q.command)
          CMD_PROGRAM, CMD_READ: state_d = S_ENQ;
          CMD_ERASE: begin
            end_d   = {1'b0, item_q.end_address};
            kind_d  = KIND_ERASE;
            tag_d   = '0;
            state_d = S_ENQ;
          end
          CMD_DONE: begin
            case (phase_q)
              PH_ENABLE: begin
                mode_d  = MODE_ENABLE;
                state_d = S_RD;
              end
              PH_PROGRAM, PH_READ: begin
                tail_d  = tail_nx;
                state_d = S_RD;
              end
              PH_ERASE: begin
                res_d   = make_xfer(op_status_q, '0, LEN_STATUS, 1'b0, '0);
                phase_d = PH_STATUS;
              end
              PH_STATUS: begin
                if (item_q.status_byte[STATUS_BUSY_BIT]) begin
                  res_d.action = ACT_TIMER;
                  phase_d      = PH_WAIT;
                end else begin
                  tail_d  = tail_nx;
                  state_d = S_RD;
                end
              end
              default: ;
            endcase
          end
          CMD_TIMER: begin
            if (phase_q == PH_WAIT) begin
              res_d   = make_xfer(op_status_q, '0, LEN_STATUS, 1'b0, '0);
              phase_d = PH_STATUS;
            end
          end
          default: ;
        endcase
      end

      // One ring slot per cycle; a plain request runs the loop once
      S_ENQ: begin
        if (a_q > end_q) begin
          state_d = busy_q ? S_OUT : S_RD;
        end else if (head_nx == tail_q) begin
          ovf_d   = 1'b1;
          state_d = busy_q ? S_OUT : S_RD;
        end else begin
          wr_en  = 1'b1;
          head_d = head_nx;
          a_d    = a_q + AW1'(ERASE_BLOCK_SIZE);
        end
      end

      S_RD: begin
        state_d = S_EXEC;
      end

      S_EXEC: begin
        state_d = S_OUT;
        if (mode_q == MODE_ENABLE) begin
          if (rd_q.kind == KIND_PROGRAM) begin
            res_d   = make_xfer(op_prog_q, ADDR_W'(rd_q.addr), page_len(page_size_q),
                                1'b1, rd_q.tag);
            phase_d = PH_PROGRAM;
          end else if (rd_q.kind == KIND_ERASE) begin
            res_d   = make_xfer(op_erase_q, ADDR_W'(rd_q.addr) & ERASE_ADDR_MASK,
                                LEN_ERASE, 1'b0, '0);
            phase_d = PH_ERASE;
          end else begin
            // write enable done for a read: retire and start the next one
            tail_d  = tail_nx;
            mode_d  = MODE_START;
            state_d = S_RD;
          end
        end else if (head_q == tail_q) begin
          res_d   = '0;
          busy_d  = 1'b0;
          phase_d = PH_IDLE;
        end else begin
          busy_d = 1'b1;
          if (rd_q.kind == KIND_READ) begin
            res_d   = make_xfer(op_read_q, ADDR_W'(rd_q.addr), page_len(page_size_q),
                                1'b1, rd_q.tag);
            phase_d = PH_READ;
          end else begin
            res_d   = make_xfer(op_wren_q, '0, LEN_ENABLE, 1'b0, '0);
            phase_d = PH_ENABLE;
          end
        end
      end

      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_START;
      head_q      <= '0;
      tail_q      <= '0;
      busy_q      <= 1'b0;
      phase_q     <= PH_IDLE;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      busy_q  <= busy_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && state_q == S_IDLE) item_q <= req_i.data;
    res_q  <= res_d;
    a_q    <= a_d;
    end_q  <= end_d;
    kind_q <= kind_d;
    tag_q  <= tag_d;
    if (state_q == S_OUT && out_free) begin
      out_q                <= res_q;
      out_q.busy_res       <= busy_q;
      out_q.queue_overflow <= ovf_q;
    end
  end

endmodule

[sv/sfcq_checker.sv]
// ----------------------------------------------------------------------------
// sfcq_checker
// Port-level checks on the result channel of the flash sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfcq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input sfcq_pkg::rsp_t rsp_data_i
);
  import sfcq_pkg::*;

  logic out_xfer;
  logic out_quiet;
  logic out_stall;
  logic out_other;
  logic out_buf;
  logic out_nobuf;
  logic out_act;

  assign out_xfer  = rsp_valid_i && (rsp_data_i.action == ACT_XFER);
  assign out_quiet = (rsp_data_i.spi_opcode == '0) && (rsp_data_i.spi_address == '0) &&
                     (rsp_data_i.transfer_length == '0) && !rsp_data_i.uses_buffer &&
                     (rsp_data_i.out_buffer_tag == '0);
  assign out_stall = rsp_valid_i && !rsp_ready_i;
  assign out_other = rsp_valid_i && (rsp_data_i.action != ACT_XFER);
  assign out_buf   = out_xfer && rsp_data_i.uses_buffer;
  assign out_nobuf = rsp_valid_i && !rsp_data_i.uses_buffer;
  assign out_act   = rsp_valid_i && (rsp_data_i.action != ACT_NONE);

  // a stalled result holds
  `SFCQ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_stall, rsp_valid_i && $stable(rsp_data_i))

  // no transfer fields unless a transfer starts
  `SFCQ_ASSERT_IMPL(a_quiet_fields, clk_i, rst_ni, out_other, out_quiet)

  // buffer transfers carry page data, others no tag
  `SFCQ_ASSERT_IMPL(a_buf_len, clk_i, rst_ni, out_buf, rsp_data_i.transfer_length > LEN_OVERHEAD)
  `SFCQ_ASSERT_IMPL(a_tag_zero, clk_i, rst_ni, out_nobuf, rsp_data_i.out_buffer_tag == '0)

  // any action implies work in flight
  `SFCQ_ASSERT_IMPL(a_busy_action, clk_i, rst_ni, out_act, rsp_data_i.busy_res)

endmodule

bind spi_flash_command_queue_sequencer_core sfcq_checker u_sfcq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .rsp_data_i (rsp_o.data)
);

[tb/tb_spi_flash_command_queue_sequencer_core.sv]
// ----------------------------------------------------------------------------
// tb_spi_flash_command_queue_sequencer_core
// Drives request and register transfers into the flash command sequencer,
// tracks its request ring and phase in a scoreboard, checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import sfcq_pkg::*;

class sequencer_tracker;
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] addr;
  } slot_t;

  slot_t              ring[QUEUE_DEPTH_DEF];
  int unsigned        head;
  int unsigned        tail;
  bit                 busy;
  logic [PHASE_W-1:0] phase;
  logic [OP_W-1:0]    op_wren;
  logic [OP_W-1:0]    op_prog;
  logic [OP_W-1:0]    op_read;
  logic [OP_W-1:0]    op_erase;
  logic [OP_W-1:0]    op_status;
  logic [LEN_W-1:0]   page_size;
  rsp_t               pending_actions[$];
  int unsigned        accepted;
  int unsigned        errors;

  function new();
    head      = 0;
    tail      = 0;
    busy      = 1'b0;
    phase     = PH_IDLE;
    op_wren   = RST_OP_WREN;
    op_prog   = RST_OP_PROG;
    op_read   = RST_OP_READ;
    op_erase  = RST_OP_ERASE;
    op_status = RST_OP_STATUS;
    page_size = RST_PAGE_SIZE;
    accepted  = 0;
    errors    = 0;
  endfunction

  function void set_register(cfg_t c);
    case (c.index)
      REG_OP_WREN:   op_wren   = c.value[OP_W-1:0];
      REG_OP_PROG:   op_prog   = c.value[OP_W-1:0];
      REG_OP_READ:   op_read   = c.value[OP_W-1:0];
      REG_OP_ERASE:  op_erase  = c.value[OP_W-1:0];
      REG_OP_STATUS: op_status = c.value[OP_W-1:0];
      REG_PAGE_SIZE: page_size = c.value;
      default: ;
    endcase
  endfunction

  // zero reads as one byte, anything past the max is clipped
  function logic [LEN_W-1:0] page_transfer_len();
    int unsigned n;
    n = page_size;
    if (n == 0) n = 1;
    else if (n > PAGE_MAX) n = PAGE_MAX;
    return LEN_W'(n) + LEN_OVERHEAD;
  endfunction

  function rsp_t start_transfer(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                logic [LEN_W-1:0] len, bit with_buffer,
                                logic [TAG_W-1:0] tag);
    rsp_t a;
    a = '0;
    a.action          = ACT_XFER;
    a.spi_opcode      = op;
    a.spi_address     = addr;
    a.transfer_length = len;
    a.uses_buffer     = with_buffer;
    if (with_buffer) a.out_buffer_tag = tag;
    return a;
  endfunction

  // ring keeps one slot free to tell full from empty
  function bit enqueue_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                               logic [TAG_W-1:0] tag);
    int unsigned next_head;
    next_head = (head + 1) % QUEUE_DEPTH_DEF;
    if (next_head == tail) return 1'b0;
    ring[head] = {kind, tag, addr};
    head = next_head;
    return 1'b1;
  endfunction

  function rsp_t start_next();
    rsp_t a;
    a = '0;
    if (head == tail) begin
      busy  = 1'b0;
      phase = PH_IDLE;
      return a;
    end
    busy = 1'b1;
    if (ring[tail].kind == KIND_READ) begin
      a = start_transfer(op_read, ring[tail].addr, page_transfer_len(), 1'b1,
                         ring[tail].tag);
      phase = PH_READ;
    end else begin
      a = start_transfer(op_wren, '0, LEN_ENABLE, 1'b0, '0);
      phase = PH_ENABLE;
    end
    return a;
  endfunction

  function rsp_t retire_head();
    tail = (tail + 1) % QUEUE_DEPTH_DEF;
    return start_next();
  endfunction

  function void note_request(req_t r);
    rsp_t        a;
    slot_t       cur;
    logic [31:0] block_addr;
    bit          dropped;
    a       = '0;
    dropped = 1'b0;
    accepted++;
    case (r.command)
      CMD_PROGRAM, CMD_READ, CMD_ERASE: begin
        if (r.command == CMD_ERASE) begin
          block_addr = 32'(r.flash_address);
          while (block_addr <= 32'(r.end_address)) begin
            if (!enqueue_request(KIND_ERASE, block_addr[ADDR_W-1:0], '0)) begin
              dropped = 1'b1;
              break;
            end
            block_addr += ERASE_BLOCK_SIZE_DEF;
          end
        end else if (!enqueue_request((r.command == CMD_READ) ? KIND_READ : KIND_PROGRAM,
                                      r.flash_address, r.buffer_tag)) begin
          dropped = 1'b1;
        end
        if (!busy) a = start_next();
      end
      CMD_DONE: begin
        cur = ring[tail];
        case (phase)
          PH_ENABLE: begin
            if (cur.kind == KIND_PROGRAM) begin
              a = start_transfer(op_prog, cur.addr, page_transfer_len(), 1'b1, cur.tag);
              phase = PH_PROGRAM;
            end else if (cur.kind == KIND_ERASE) begin
              a = start_transfer(op_erase, cur.addr & ERASE_ADDR_MASK, LEN_ERASE,
                                 1'b0, '0);
              phase = PH_ERASE;
            end else begin
              a = retire_head();
            end
          end
          PH_PROGRAM, PH_READ: a = retire_head();
          PH_ERASE: begin
            a = start_transfer(op_status, '0, LEN_STATUS, 1'b0, '0);
            phase = PH_STATUS;
          end
          PH_STATUS: begin
            if (r.status_byte[STATUS_BUSY_BIT]) begin
              a.action = ACT_TIMER;
              phase    = PH_WAIT;
            end else begin
              a = retire_head();
            end
          end
          default: ;
        endcase
      end
      CMD_TIMER: begin
        if (phase == PH_WAIT) begin
          a = start_transfer(op_status, '0, LEN_STATUS, 1'b0, '0);
          phase = PH_STATUS;
        end
      end
      default: ;
    endcase
    a.busy_res       = busy;
    a.queue_overflow = dropped;
    pending_actions.push_back(a);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_action(rsp_t got);
    rsp_t want;
    if (pending_actions.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected nothing actual %h", $time, got);
      return;
    end
    want = pending_actions.pop_front();
    compare_field("action", want.action, got.action);
    compare_field("spi_opcode", want.spi_opcode, got.spi_opcode);
    compare_field("spi_address", want.spi_address, got.spi_address);
    compare_field("transfer_length", want.transfer_length, got.transfer_length);
    compare_field("uses_buffer", want.uses_buffer, got.uses_buffer);
    compare_field("out_buffer_tag", want.out_buffer_tag, got.out_buffer_tag);
    compare_field("busy_res", want.busy_res, got.busy_res);
    compare_field("queue_overflow", want.queue_overflow, got.queue_overflow);
  endfunction
endclass

module tb_spi_flash_command_queue_sequencer_core;

  localparam int unsigned PHASE_ITEMS     = 130;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES   = 300;
  localparam int unsigned PRESSURE_AFTER  = 250;
  localparam int unsigned PRESSURE_CYCLES = 400;

  localparam logic [CMD_W-1:0] CMD_RESERVED_LO = CMD_TIMER + 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVED_HI = '1;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
    REG_OP_WREN, REG_OP_PROG, REG_OP_READ, REG_OP_ERASE, REG_OP_STATUS, REG_PAGE_SIZE
  };

  logic clk_i;
  logic rst_ni;
  bit   steady_flow;

  sequencer_tracker tracker = new();

  sfcq_stream_if #(.T(req_t)) req_if (.clk_i(clk_i), .rst_ni(rst_ni));
  sfcq_stream_if #(.T(rsp_t)) rsp_if (.clk_i(clk_i), .rst_ni(rst_ni));
  sfcq_stream_if #(.T(cfg_t)) cfg_if (.clk_i(clk_i), .rst_ni(rst_ni));

  spi_flash_command_queue_sequencer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                        logic [ADDR_W-1:0] last, logic [TAG_W-1:0] tag,
                                        logic [7:0] status);
    req_t r;
    r.command       = cmd;
    r.flash_address = addr;
    r.end_address   = last;
    r.buffer_tag    = tag;
    r.status_byte   = status;
    return r;
  endfunction

  // Mostly what the sequencer waits for next, with enqueues mixed in and
  // some events that it has to ignore.
  function automatic req_t random_request();
    req_t        r;
    int unsigned sel;
    int unsigned pick;
    logic [31:0] last;
    bit          running;
    r = make_request(CMD_DONE, ADDR_W'($urandom()), ADDR_W'($urandom()),
                     TAG_W'($urandom()), 8'($urandom()));
    running = tracker.phase inside {PH_ENABLE, PH_PROGRAM, PH_READ, PH_ERASE, PH_STATUS};
    sel = $urandom_range(0, 99);
    if (tracker.phase == PH_WAIT && sel < 75) begin
      r.command = CMD_TIMER;
    end else if (running && sel < 65) begin
      r.status_byte[STATUS_BUSY_BIT] = ($urandom_range(0, 99) < 40);
    end else if (sel < ((running || tracker.phase == PH_WAIT) ? 88 : 75)) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        r.command = CMD_PROGRAM;
      end else if (pick < 8) begin
        r.command = CMD_READ;
      end else begin
        r.command = CMD_ERASE;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          r.end_address = '1;  // up to the top: usually floods the ring
        end else if (pick < 4) begin
          if (r.flash_address == '0) r.flash_address = 24'd1;
          r.end_address = ADDR_W'($urandom_range(0, r.flash_address - 1));
        end else begin
          last = 32'(r.flash_address) + $urandom_range(0, 3 * ERASE_BLOCK_SIZE_DEF);
          r.end_address = (last > 32'h00FF_FFFF) ? '1 : last[ADDR_W-1:0];
        end
      end
    end else begin
      pick = $urandom_range(0, 2);
      if (pick == 0) r.command = CMD_DONE;
      else if (pick == 1) r.command = CMD_TIMER;
      else r.command = CMD_RESERVED_LO + CMD_W'($urandom_range(0, 2));
    end
    return r;
  endfunction

  task automatic send_request(req_t r);
    int unsigned gap;
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(r);
    gap = steady_flow ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_VAL_W-1:0] value);
    cfg_t c;
    c.index = idx;
    c.value = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_register(c);
  endtask

  initial begin : result_sink
    int unsigned hold;
    bit          squeezed;
    hold     = 0;
    squeezed = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) tracker.check_action(rsp_if.data);
      if (hold != 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (!squeezed && tracker.accepted >= PRESSURE_AFTER) begin
        // one long hold-off so results back up and the request side stalls
        squeezed = 1'b1;
        hold     = PRESSURE_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        hold = steady_flow ? 0 : pick_gap();
        if (hold == 0) begin
          rsp_if.ready <= 1'b1;
        end else begin
          hold--;
          rsp_if.ready <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    req_t                 directed[$];
    req_t                 r;
    int unsigned          effective;
    logic [CFG_VAL_W-1:0] value;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    steady_flow  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      make_request(CMD_PROGRAM, '0, '0, '0, '0),
      make_request(CMD_DONE, '0, '0, '0, '0),
      make_request(CMD_DONE, '0, '0, '0, '0),
      make_request(CMD_DONE, '1, '1, '1, '1),              // done while idle
      make_request(CMD_TIMER, '0, '0, '0, '0),             // timer out of turn
      make_request(CMD_RESERVED_LO, '1, '1, '1, '1),
      make_request(CMD_RESERVED_HI, '0, '0, '0, '0),
      make_request(CMD_READ, '1, '0, '1, '0),
      make_request(CMD_TIMER, '0, '0, '0, '0),
      make_request(CMD_DONE, '0, '0, '0, '0),
      make_request(CMD_ERASE, '1, '1, '0, '0),
      make_request(CMD_DONE, '0, '0, '0, '0),
      make_request(CMD_DONE, '0, '0, '0, '1),
      make_request(CMD_DONE, '0, '0, '0, 8'h01),           // flash still busy
      make_request(CMD_DONE, '0, '0, '0, '0),              // done during timer wait
      make_request(CMD_TIMER, '0, '0, '0, '0),
      make_request(CMD_DONE, '0, '0, '0, 8'hFE),
      make_request(CMD_ERASE, 24'h000010, '0, '0, '0),     // empty range
      make_request(CMD_ERASE, '0, '1, '0, '0),             // overruns the ring
      make_request(CMD_PROGRAM, 24'h123456, '0, 8'h5A, '0),
      make_request(CMD_READ, 24'h654321, '0, 8'hA5, '0)
    };
    foreach (directed[i]) send_request(directed[i]);

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        req_if.valid <= 1'b0;
        while (tracker.pending_actions.size() != 0) @(posedge clk_i);
        repeat (SETTLE_CYCLES) @(posedge clk_i);
        foreach (REG_ORDER[i]) begin
          case (p)
            1: value = '0;
            2: value = '1;
            3: value = (REG_ORDER[i] == REG_PAGE_SIZE) ? CFG_VAL_W'(PAGE_MAX) :
                                                         CFG_VAL_W'($urandom_range(0, 255));
            4: value = (REG_ORDER[i] == REG_PAGE_SIZE) ? CFG_VAL_W'(1) :
                                                         CFG_VAL_W'($urandom_range(0, 255));
            default: begin
              if (REG_ORDER[i] != REG_PAGE_SIZE) value = CFG_VAL_W'($urandom());
              else if ($urandom_range(0, 99) < 80) value = CFG_VAL_W'($urandom_range(1, 4096));
              else value = CFG_VAL_W'($urandom_range(4097, 8191));
            end
          endcase
          program_register(REG_ORDER[i], value);
        end
        cfg_if.valid <= 1'b0;
      end
      steady_flow = (p == 2 || p == 4);
      effective   = 0;
      while (effective < PHASE_ITEMS) begin
        r = random_request();
        if (r.command <= CMD_ERASE ||
            (r.command == CMD_DONE &&
             tracker.phase inside {PH_ENABLE, PH_PROGRAM, PH_READ, PH_ERASE, PH_STATUS}) ||
            (r.command == CMD_TIMER && tracker.phase == PH_WAIT))
          effective++;
        send_request(r);
      end
    end

    req_if.valid <= 1'b0;
    while (tracker.pending_actions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.pending_actions.size() != 0)
      $display("%0t: %0d expected results never arrived", $time,
               tracker.pending_actions.size());
    if (tracker.errors == 0 && tracker.pending_actions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sfcq_pkg.sv
sv/sfcq_stream_if.sv
sv/spi_flash_command_queue_sequencer_core.sv
sv/sfcq_checker.sv
tb/tb_spi_flash_command_queue_sequencer_core.sv
